/* src/pvw_pkg.sv */
// Package: shared types and character constants for the printf vararg widener.
`timescale 1ns / 1ps
`default_nettype none
package pvw_pkg;

  // Width of a format character code (narrow byte or wide code point)
  localparam int unsigned CHAR_W  = 21;
  localparam int unsigned INDEX_W = 8;

  // Character codes that steer the parser
  localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CH_LOW_L   = 8'h6C;  // 'l'
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UP_L    = 8'h4C;  // 'L'
  localparam logic [7:0] CH_STAR    = 8'h2A;  // '*'
  localparam logic [7:0] CH_LOW_H   = 8'h68;  // 'h'
  localparam logic [7:0] CH_LOW_M   = 8'h6D;  // 'm'
  localparam logic [7:0] CH_DOLLAR  = 8'h24;  // '$'

  // Depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    MK_ZERO_EXT = 2'd0,
    MK_SIGN_EXT = 2'd1,
    MK_PAIR     = 2'd2,
    MK_EXT_PREC = 2'd3
  } move_kind_t;

  typedef enum logic [4:0] {
    PS_IDLE = 5'b00001,
    PS_PCT  = 5'b00010,
    PS_L    = 5'b00100,
    PS_LL   = 5'b01000,
    PS_BIGL = 5'b10000
  } parse_state_t;

  // One command from the classifier to the index engine
  typedef struct packed {
    logic       emit;   // produce a move descriptor
    move_kind_t kind;
    logic       clear;  // clear both counts after this command
  } pvw_cmd_t;

endpackage
`default_nettype wire

/* src/pvw_in_if.sv */
// Interface: format character channel.
`timescale 1ns / 1ps
`default_nettype none
interface pvw_in_if;
  logic                         valid;
  logic                         ready;
  logic [pvw_pkg::CHAR_W-1:0]   format_char;
  logic                         end_of_format;

  modport source (output valid, format_char, end_of_format, input ready);
  modport sink   (input valid, format_char, end_of_format, output ready);
endinterface
`default_nettype wire

/* src/pvw_out_if.sv */
// Interface: move descriptor channel.
`timescale 1ns / 1ps
`default_nettype none
interface pvw_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    move_kind;
  logic [pvw_pkg::INDEX_W-1:0]   source_word_index;
  logic [pvw_pkg::INDEX_W-1:0]   dest_slot_index;
  logic                          index_overflow;

  modport source (output valid, move_kind, source_word_index, dest_slot_index,
                  index_overflow, input ready);
  modport sink   (input valid, move_kind, source_word_index, dest_slot_index,
                  index_overflow, output ready);
endinterface
`default_nettype wire

/* src/pvw_front.sv */
// Front: accept format characters, track the conversion state, issue commands.
`timescale 1ns / 1ps
`default_nettype none
module pvw_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  pvw_in_if.sink             in_ch,
  input  wire logic          q_full,
  output logic               q_push,
  output pvw_pkg::pvw_cmd_t  q_cmd
);

  pvw_pkg::parse_state_t state_r, state_nxt;
  pvw_pkg::pvw_cmd_t     cmd;
  logic                  accept;
  logic                  is_ascii;
  logic [7:0]            c8;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_ascii    = (in_ch.format_char[pvw_pkg::CHAR_W-1:7] == '0);
  assign c8          = in_ch.format_char[7:0];

  always_comb begin
    state_nxt  = state_r;
    cmd.emit   = 1'b0;
    cmd.kind   = pvw_pkg::MK_ZERO_EXT;
    cmd.clear  = 1'b0;
    if (in_ch.format_char == '0) begin
      state_nxt = pvw_pkg::PS_IDLE;
      cmd.clear = 1'b1;
    end else if (state_r == pvw_pkg::PS_IDLE) begin
      if (is_ascii && c8 == pvw_pkg::CH_PERCENT) state_nxt = pvw_pkg::PS_PCT;
    end else if (!is_ascii) begin
      // wide code points are plain one-word conversions
      state_nxt = pvw_pkg::PS_IDLE;
      cmd.emit  = 1'b1;
    end else begin
      case (c8)
        pvw_pkg::CH_PERCENT: state_nxt = pvw_pkg::PS_IDLE;
        pvw_pkg::CH_LOW_L: begin
          if (state_r == pvw_pkg::PS_PCT) state_nxt = pvw_pkg::PS_L;
          else                            state_nxt = pvw_pkg::PS_LL;
        end
        pvw_pkg::CH_LOW_Z: state_nxt = pvw_pkg::PS_L;
        pvw_pkg::CH_UP_L:  state_nxt = pvw_pkg::PS_BIGL;
        "a", "A", "e", "E", "f", "F", "g", "G": begin
          state_nxt = pvw_pkg::PS_IDLE;
          cmd.emit  = 1'b1;
          cmd.kind  = (state_r == pvw_pkg::PS_BIGL) ? pvw_pkg::MK_EXT_PREC
                                                    : pvw_pkg::MK_PAIR;
        end
        "d", "i", "o": begin
          state_nxt = pvw_pkg::PS_IDLE;
          cmd.emit  = 1'b1;
          if (state_r == pvw_pkg::PS_L)       cmd.kind = pvw_pkg::MK_SIGN_EXT;
          else if (state_r == pvw_pkg::PS_LL) cmd.kind = pvw_pkg::MK_PAIR;
        end
        "u", "x", "X": begin
          state_nxt = pvw_pkg::PS_IDLE;
          // long double size on an unsigned conversion moves nothing
          cmd.emit  = (state_r != pvw_pkg::PS_BIGL);
          if (state_r == pvw_pkg::PS_LL) cmd.kind = pvw_pkg::MK_PAIR;
        end
        pvw_pkg::CH_LOW_H, pvw_pkg::CH_DOLLAR, "'", ".", "+", "-", "#",
        "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": ;
        pvw_pkg::CH_LOW_M, " ": state_nxt = pvw_pkg::PS_IDLE;
        pvw_pkg::CH_STAR: cmd.emit = 1'b1;
        default: begin
          state_nxt = pvw_pkg::PS_IDLE;
          cmd.emit  = 1'b1;
        end
      endcase
    end
    if (in_ch.end_of_format) begin
      state_nxt = pvw_pkg::PS_IDLE;
      cmd.clear = 1'b1;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (cmd.emit || cmd.clear);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pvw_pkg::PS_IDLE;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/pvw_queue.sv */
// Queue: short command FIFO between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module pvw_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire pvw_pkg::pvw_cmd_t  push_cmd,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output pvw_pkg::pvw_cmd_t       head_cmd
);

  localparam int unsigned CW = $clog2(pvw_pkg::QUEUE_DEPTH + 1);

  pvw_pkg::pvw_cmd_t            slot_r [pvw_pkg::QUEUE_DEPTH];
  logic [pvw_pkg::QUEUE_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]                count_r;
  logic                         do_push, do_pop;

  assign full       = (count_r == CW'(pvw_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* src/pvw_back.sv */
// Back: run the word and slot counters and register move descriptors.
`timescale 1ns / 1ps
`default_nettype none
module pvw_back #(
  parameter int unsigned MAX_WORDS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  wire pvw_pkg::pvw_cmd_t  head_cmd,
  output logic                    pop,
  pvw_out_if.source               out_ch
);

  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam int unsigned XW = (CW + 1 > pvw_pkg::INDEX_W + 1) ? CW + 1
                                                              : pvw_pkg::INDEX_W + 1;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_WORDS);
  localparam logic [XW-1:0] IDX_MAX_X = XW'((1 << pvw_pkg::INDEX_W) - 1);

  logic [CW-1:0] src_cnt_r, dst_cnt_r;
  logic [CW-1:0] src_cnt_nxt, dst_cnt_nxt;
  logic [XW-1:0] s_x, d_x, s_sum, d_sum, n_src, n_dst;
  logic          ovf;
  logic          o_valid_r;
  logic [1:0]    o_kind_r;
  logic [pvw_pkg::INDEX_W-1:0] o_src_r, o_dst_r;
  logic          o_ovf_r;

  assign pop = head_valid && (!head_cmd.emit || !o_valid_r || out_ch.ready);

  always_comb begin
    case (head_cmd.kind)
      pvw_pkg::MK_EXT_PREC: begin n_src = XW'(3); n_dst = XW'(2); end
      pvw_pkg::MK_PAIR:     begin n_src = XW'(2); n_dst = XW'(1); end
      default:              begin n_src = XW'(1); n_dst = XW'(1); end
    endcase
    s_x   = XW'(src_cnt_r);
    d_x   = XW'(dst_cnt_r);
    s_sum = s_x + n_src;
    d_sum = d_x + n_dst;
    ovf   = (s_sum > MAX_X) || (d_sum > MAX_X) || (s_x > IDX_MAX_X) || (d_x > IDX_MAX_X);
    src_cnt_nxt = src_cnt_r;
    dst_cnt_nxt = dst_cnt_r;
    if (head_cmd.emit) begin
      src_cnt_nxt = (s_sum > MAX_X) ? CW'(MAX_WORDS) : s_sum[CW-1:0];
      dst_cnt_nxt = (d_sum > MAX_X) ? CW'(MAX_WORDS) : d_sum[CW-1:0];
    end
    if (head_cmd.clear) begin
      src_cnt_nxt = '0;
      dst_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r <= '0;
      dst_cnt_r <= '0;
      o_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        src_cnt_r <= src_cnt_nxt;
        dst_cnt_r <= dst_cnt_nxt;
      end
      if (pop && head_cmd.emit) o_valid_r <= 1'b1;
      else if (out_ch.ready)    o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_cmd.emit) begin
      o_kind_r <= head_cmd.kind;
      o_src_r  <= (s_x > IDX_MAX_X) ? IDX_MAX_X[pvw_pkg::INDEX_W-1:0]
                                    : s_x[pvw_pkg::INDEX_W-1:0];
      o_dst_r  <= (d_x > IDX_MAX_X) ? IDX_MAX_X[pvw_pkg::INDEX_W-1:0]
                                    : d_x[pvw_pkg::INDEX_W-1:0];
      o_ovf_r  <= ovf;
    end
  end

  assign out_ch.valid             = o_valid_r;
  assign out_ch.move_kind         = o_kind_r;
  assign out_ch.source_word_index = o_src_r;
  assign out_ch.dest_slot_index   = o_dst_r;
  assign out_ch.index_overflow    = o_ovf_r;

endmodule
`default_nettype wire

/* src/printf_vararg_widener.sv */
// Top level: printf format parser that emits argument widening descriptors.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          format_char[20:0], end_of_format
//   out_ch   out  valid/ready          move_kind[1:0], source_word_index[7:0],
//                                      dest_slot_index[7:0], index_overflow
//
// One character is accepted every cycle while the command queue has room.
// A descriptor passes from its character through the command queue, then
// the back's output register; counters update once per popped command.
// Synchronous active-low reset returns the parser to idle, empties the queue
// and clears both counts. Output stalls back up into the four-entry queue and
// then drop in_ch.ready; characters that neither move an argument nor clear
// the counts skip the queue.
`timescale 1ns / 1ps
`default_nettype none
module printf_vararg_widener #(
  parameter int unsigned MAX_WORDS = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pvw_in_if.sink    in_ch,
  pvw_out_if.source out_ch
);

  pvw_pkg::pvw_cmd_t push_cmd, head_cmd;
  logic              push, q_full, pop, head_valid;

  // Classify characters and track the conversion size modifier
  pvw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (push),
    .q_cmd  (push_cmd)
  );

  // Decouple the classifier from the descriptor output
  pvw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Advance word and slot counts, present each transaction
  pvw_back #(
    .MAX_WORDS (MAX_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
